// ===== rtl/core/color_key_bounding_box_core_macros.svh =====
// Assertion macros shared by the color-key bounding box RTL.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef COLOR_KEY_BOUNDING_BOX_CORE_MACROS_SVH
`define COLOR_KEY_BOUNDING_BOX_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CKBB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ckbb assertion failed");
`define CKBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ckbb assertion failed");
`else
`define CKBB_ASSERT(lbl, clk, rst_n, prop)
`define CKBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ckbb_pkg.sv =====
// Package for the color-key bounding box core: widths, register codes,
// payload structs and the dimension/scaling helpers. No dependencies.
`timescale 1ns / 1ps

package ckbb_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int SCALE_SHIFT = 2;

    localparam int COLOR_W   = 8;
    localparam int CFG_DIM_W = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 10;
    localparam int OUT_MAX   = 1023;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int EFF_W = $clog2(MAX_DIM + 1);

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_RED      = 3'd0,
        REG_KEY_GREEN    = 3'd1,
        REG_KEY_BLUE     = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        t_pixel           key;
        logic [EFF_W-1:0] width;
        logic [EFF_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] width;
        logic [OUT_W-1:0] height;
        logic             found;
    } t_box;

    // zero reads as one, anything above MAX_DIM as MAX_DIM
    function automatic logic [EFF_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        if (v == '0) begin
            return EFF_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            return EFF_W'(MAX_DIM);
        end else begin
            return EFF_W'(v);
        end
    endfunction

    function automatic logic [OUT_W-1:0] scale_sat(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] s;
        s = v >> SCALE_SHIFT;
        if (32'(s) > 32'(OUT_MAX)) begin
            return OUT_W'(OUT_MAX);
        end else begin
            return OUT_W'(s);
        end
    endfunction

endpackage

// ===== rtl/core/ckbb_pixel_if.sv =====
// Pixel stream channel: valid/ready handshake with blue, green, red bytes.
// Depends on ckbb_pkg.
`timescale 1ns / 1ps

interface ckbb_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [ckbb_pkg::COLOR_W-1:0] pixel_blue;
    logic [ckbb_pkg::COLOR_W-1:0] pixel_green;
    logic [ckbb_pkg::COLOR_W-1:0] pixel_red;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

// ===== rtl/core/ckbb_box_if.sv =====
// Bounding box result channel: valid/ready handshake with box fields.
// Depends on ckbb_pkg.
`timescale 1ns / 1ps

interface ckbb_box_if;
    logic                        valid;
    logic                        ready;
    logic [ckbb_pkg::OUT_W-1:0]  box_left;
    logic [ckbb_pkg::OUT_W-1:0]  box_top;
    logic [ckbb_pkg::OUT_W-1:0]  box_width;
    logic [ckbb_pkg::OUT_W-1:0]  box_height;
    logic                        found;

    modport source (output valid, box_left, box_top, box_width, box_height, found,
                    input ready);
    modport sink   (input valid, box_left, box_top, box_width, box_height, found,
                    output ready);
endinterface

// ===== rtl/core/ckbb_cfg_regs.sv =====
// Configuration register file: key color and clamped frame dimensions.
// Depends on ckbb_pkg.
`timescale 1ns / 1ps

module ckbb_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ckbb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckbb_pkg::CFG_W-1:0]       i_cfg_data,
    output ckbb_pkg::t_cfg                   o_cfg
);

    ckbb_pkg::t_pixel                    r_key;
    logic [ckbb_pkg::CFG_DIM_W-1:0]      r_width;
    logic [ckbb_pkg::CFG_DIM_W-1:0]      r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_width  <= ckbb_pkg::WIDTH_RESET;
            r_height <= ckbb_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ckbb_pkg::REG_KEY_RED: begin
                    r_key.red <= i_cfg_data[ckbb_pkg::COLOR_W-1:0];
                end
                ckbb_pkg::REG_KEY_GREEN: begin
                    r_key.green <= i_cfg_data[ckbb_pkg::COLOR_W-1:0];
                end
                ckbb_pkg::REG_KEY_BLUE: begin
                    r_key.blue <= i_cfg_data[ckbb_pkg::COLOR_W-1:0];
                end
                ckbb_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[ckbb_pkg::CFG_DIM_W-1:0];
                end
                ckbb_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[ckbb_pkg::CFG_DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.key    = r_key;
        o_cfg.width  = ckbb_pkg::clamp_dim(r_width);
        o_cfg.height = ckbb_pkg::clamp_dim(r_height);
    end

endmodule

// ===== rtl/core/ckbb_tracker.sv =====
// Input register plus frame tracker: raster counters, min/max extents and
// the end-of-frame box result. Depends on ckbb_pkg and the macros header.
`timescale 1ns / 1ps
`include "color_key_bounding_box_core_macros.svh"

module ckbb_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ckbb_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  ckbb_pkg::t_pixel  i_pixel,
    output logic              o_ready,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output ckbb_pkg::t_box    o_res
);

    logic                          r_in_valid;
    ckbb_pkg::t_pixel              r_pixel;
    logic [ckbb_pkg::CNT_W-1:0]    r_col, r_row;
    logic [ckbb_pkg::CNT_W-1:0]    r_min_col, r_max_col, r_min_row, r_max_row;
    logic                          r_any_seen;

    logic [ckbb_pkg::CNT_W-1:0]    n_min_col, n_max_col, n_min_row, n_max_row;
    logic                          n_any_seen;
    logic                          is_obj, last_col, last_row, frame_end, advance;

    always_comb begin
        is_obj     = (r_pixel != i_cfg.key);
        n_min_col  = (is_obj && (r_col < r_min_col)) ? r_col : r_min_col;
        n_max_col  = (is_obj && (r_col > r_max_col)) ? r_col : r_max_col;
        n_min_row  = (is_obj && (r_row < r_min_row)) ? r_row : r_min_row;
        n_max_row  = (is_obj && (r_row > r_max_row)) ? r_row : r_max_row;
        n_any_seen = r_any_seen | is_obj;

        last_col  = (ckbb_pkg::EFF_W'(r_col) + ckbb_pkg::EFF_W'(1)) >= i_cfg.width;
        last_row  = (ckbb_pkg::EFF_W'(r_row) + ckbb_pkg::EFF_W'(1)) >= i_cfg.height;
        frame_end = last_col && last_row;

        advance     = r_in_valid && (!frame_end || i_out_free);
        o_ready     = !r_in_valid || advance;
        o_res_valid = r_in_valid && frame_end && i_out_free;

        if (n_any_seen) begin
            o_res.left   = ckbb_pkg::scale_sat(n_min_col);
            o_res.top    = ckbb_pkg::scale_sat(n_min_row);
            o_res.width  = ckbb_pkg::scale_sat(n_max_col - n_min_col);
            o_res.height = ckbb_pkg::scale_sat(n_max_row - n_min_row);
            o_res.found  = 1'b1;
        end else begin
            o_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pixel <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_min_col  <= '1;
            r_max_col  <= '0;
            r_min_row  <= '1;
            r_max_row  <= '0;
            r_any_seen <= 1'b0;
        end else if (advance) begin
            if (frame_end) begin
                r_col      <= '0;
                r_row      <= '0;
                r_min_col  <= '1;
                r_max_col  <= '0;
                r_min_row  <= '1;
                r_max_row  <= '0;
                r_any_seen <= 1'b0;
            end else begin
                r_min_col  <= n_min_col;
                r_max_col  <= n_max_col;
                r_min_row  <= n_min_row;
                r_max_row  <= n_max_row;
                r_any_seen <= n_any_seen;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + ckbb_pkg::CNT_W'(1);
                end else begin
                    r_col <= r_col + ckbb_pkg::CNT_W'(1);
                end
            end
        end
    end

    `CKBB_ASSERT(a_empty_extents, i_clk, i_rst_n, !r_any_seen |-> (r_min_col == '1 && r_max_col == '0 && r_min_row == '1 && r_max_row == '0))
    `CKBB_ASSERT(a_ordered_extents, i_clk, i_rst_n, r_any_seen |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
    `CKBB_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_pixel))

endmodule

// ===== rtl/core/ckbb_out_reg.sv =====
// Result register for the box channel; loads when empty or being drained.
// Depends on ckbb_pkg and the macros header.
`timescale 1ns / 1ps
`include "color_key_bounding_box_core_macros.svh"

module ckbb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ckbb_pkg::t_box   i_box,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ckbb_pkg::t_box   o_box
);

    logic            r_valid;
    ckbb_pkg::t_box  r_box;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_box   = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_box;
        end
    end

    `CKBB_ASSERT(a_load_only_when_free, i_clk, i_rst_n, i_load |-> o_free)

endmodule

// ===== rtl/core/color_key_bounding_box_core.sv =====
// Color-key bounding box core: per-frame extent of pixels that differ from
// a key color. Depends on ckbb_pkg, ckbb_pixel_if, ckbb_box_if and submodules.
//
// Usage:
//   i_pix  : pixel stream in raster order (blue, green, red bytes), valid/ready.
//   o_box  : one transaction per frame, after the frame's last pixel: box left,
//            top, width, height (all in pixels, divided by 4) and found.
//   cfg    : write port (i_cfg_we, i_cfg_index, i_cfg_data) for key color and
//            frame size; write only while no frame is in progress.
// Throughput: one pixel per cycle while no waiting result stalls the input,
//   set by the single input register to result register path; counters and
//   extents update once per pixel.
// Result: computed from the last pixel in the input register, then registered.
// Reset: clears counters and extents, empties both registers; key color 0,
//   frame 640 x 480.
// Stall: a waiting result holds the last pixel of the next frame in the input
//   register and no new pixel is taken meanwhile; pixels before it flow on.
`timescale 1ns / 1ps

module color_key_bounding_box_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ckbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckbb_pkg::CFG_W-1:0]      i_cfg_data,
    ckbb_pixel_if.sink                      i_pix,
    ckbb_box_if.source                      o_box
);

    ckbb_pkg::t_cfg    cfg;
    ckbb_pkg::t_pixel  pixel;
    ckbb_pkg::t_box    res, box;
    logic              res_valid, out_free;

    assign pixel.blue  = i_pix.pixel_blue;
    assign pixel.green = i_pix.pixel_green;
    assign pixel.red   = i_pix.pixel_red;

    ckbb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ckbb_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_pix.valid),
        .i_pixel     (pixel),
        .o_ready     (i_pix.ready),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ckbb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_box   (res),
        .o_free  (out_free),
        .o_valid (o_box.valid),
        .i_ready (o_box.ready),
        .o_box   (box)
    );

    assign o_box.box_left   = box.left;
    assign o_box.box_top    = box.top;
    assign o_box.box_width  = box.width;
    assign o_box.box_height = box.height;
    assign o_box.found      = box.found;

endmodule

// ===== bench/ckbb_box_checker.sv =====
// Scoreboard for color_key_bounding_box_core: mirrors register writes, predicts
// one box per frame from accepted pixels and checks the result channel.
// Depends on ckbb_pkg, ckbb_pixel_if and ckbb_box_if.
`timescale 1ns / 1ps

module ckbb_box_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ckbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ckbb_pkg::CFG_W-1:0]     i_cfg_data,
    ckbb_pixel_if                          i_pix,
    ckbb_box_if                            i_box,
    output int                             o_fail_count,
    output int                             o_pending
);

    ckbb_pkg::t_pixel                 key_color;
    logic [ckbb_pkg::CFG_DIM_W-1:0]   width_cfg;
    logic [ckbb_pkg::CFG_DIM_W-1:0]   height_cfg;
    logic [ckbb_pkg::CNT_W-1:0]       col_pos;
    logic [ckbb_pkg::CNT_W-1:0]       row_pos;
    logic [ckbb_pkg::CNT_W-1:0]       min_col;
    logic [ckbb_pkg::CNT_W-1:0]       max_col;
    logic [ckbb_pkg::CNT_W-1:0]       min_row;
    logic [ckbb_pkg::CNT_W-1:0]       max_row;
    logic                             any_seen;
    ckbb_pkg::t_box                   pending_boxes[$];

    function automatic int frame_extent(input logic [ckbb_pkg::CFG_DIM_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) begin
            n = 1;
        end
        if (n > ckbb_pkg::MAX_DIM) begin
            n = ckbb_pkg::MAX_DIM;
        end
        return n;
    endfunction

    function automatic logic [ckbb_pkg::OUT_W-1:0] quarter_sat(
        input logic [ckbb_pkg::CNT_W-1:0] v);
        int q;
        q = int'(v) >> ckbb_pkg::SCALE_SHIFT;
        if (q > ckbb_pkg::OUT_MAX) begin
            return ckbb_pkg::OUT_W'(ckbb_pkg::OUT_MAX);
        end
        return ckbb_pkg::OUT_W'(q);
    endfunction

    function automatic void clear_extent();
        col_pos = '0;
        row_pos = '0;
        min_col = '1;
        max_col = '0;
        min_row = '1;
        max_row = '0;
        any_seen = 1'b0;
    endfunction

    function automatic void apply_write(input logic [ckbb_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [ckbb_pkg::CFG_W-1:0] val);
        case (idx)
            ckbb_pkg::REG_KEY_RED:      key_color.red = val[ckbb_pkg::COLOR_W-1:0];
            ckbb_pkg::REG_KEY_GREEN:    key_color.green = val[ckbb_pkg::COLOR_W-1:0];
            ckbb_pkg::REG_KEY_BLUE:     key_color.blue = val[ckbb_pkg::COLOR_W-1:0];
            ckbb_pkg::REG_IMAGE_WIDTH:  width_cfg = val[ckbb_pkg::CFG_DIM_W-1:0];
            ckbb_pkg::REG_IMAGE_HEIGHT: height_cfg = val[ckbb_pkg::CFG_DIM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void track_pixel(input ckbb_pkg::t_pixel px);
        ckbb_pkg::t_box res;
        if (px != key_color) begin
            if (col_pos < min_col) min_col = col_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (row_pos > max_row) max_row = row_pos;
            any_seen = 1'b1;
        end
        if (int'(col_pos) + 1 < frame_extent(width_cfg)) begin
            col_pos = col_pos + 1'b1;
            return;
        end
        col_pos = '0;
        if (int'(row_pos) + 1 < frame_extent(height_cfg)) begin
            row_pos = row_pos + 1'b1;
            return;
        end
        res = '0;
        if (any_seen) begin
            res.left = quarter_sat(min_col);
            res.top = quarter_sat(min_row);
            res.width = quarter_sat(max_col - min_col);
            res.height = quarter_sat(max_row - min_row);
            res.found = 1'b1;
        end
        pending_boxes.push_back(res);
        clear_extent();
    endfunction

    function automatic void check_box(input ckbb_pkg::t_box got);
        ckbb_pkg::t_box want;
        if (pending_boxes.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: box with no frame pending: left=%0d top=%0d w=%0d h=%0d f=%0d",
                         $time, got.left, got.top, got.width, got.height, got.found);
            end
            return;
        end
        want = pending_boxes.pop_front();
        if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
            got.height !== want.height || got.found !== want.found) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: box mismatch: expected left=%0d top=%0d w=%0d h=%0d f=%0d",
                         $time, want.left, want.top, want.width, want.height, want.found);
                $display("%0t:               got      left=%0d top=%0d w=%0d h=%0d f=%0d",
                         $time, got.left, got.top, got.width, got.height, got.found);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        ckbb_pkg::t_box   got;
        ckbb_pkg::t_pixel px;
        if (!i_rst_n) begin
            key_color = '0;
            width_cfg = ckbb_pkg::WIDTH_RESET;
            height_cfg = ckbb_pkg::HEIGHT_RESET;
            clear_extent();
            pending_boxes.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                apply_write(i_cfg_index, i_cfg_data);
            end
            // check before tracking: a box can never leave on its last pixel's edge
            if (i_box.valid && i_box.ready) begin
                got.left = i_box.box_left;
                got.top = i_box.box_top;
                got.width = i_box.box_width;
                got.height = i_box.box_height;
                got.found = i_box.found;
                check_box(got);
            end
            if (i_pix.valid && i_pix.ready) begin
                px.blue = i_pix.pixel_blue;
                px.green = i_pix.pixel_green;
                px.red = i_pix.pixel_red;
                track_pixel(px);
            end
        end
        o_pending = pending_boxes.size();
    end

endmodule

// ===== bench/color_key_bounding_box_core_test.sv =====
// Testbench top for color_key_bounding_box_core: clock, reset, register writes,
// pixel frames and result back-pressure; verdict from ckbb_box_checker.
// Depends on ckbb_pkg, ckbb_pixel_if, ckbb_box_if and ckbb_box_checker.
`timescale 1ns / 1ps

module color_key_bounding_box_core_test;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int ITEMS_PER_PASS  = 200;
    localparam int STALL_CYCLES    = 300;
    localparam int DRAIN_CYCLES    = 4;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [ckbb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ckbb_pkg::CFG_W-1:0]     cfg_data;
    int                             fail_count;
    int                             pending;

    int               cycle_count = 0;
    int               items_sent = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               stall_len = 0;
    int               stall_gen = 0;
    ckbb_pkg::t_pixel key_px = '0;
    int               size_w = int'(ckbb_pkg::WIDTH_RESET);
    int               size_h = int'(ckbb_pkg::HEIGHT_RESET);

    ckbb_pixel_if pix_ch ();
    ckbb_box_if   box_ch ();

    color_key_bounding_box_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch),
        .o_box       (box_ch)
    );

    ckbb_box_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_ch),
        .i_box        (box_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random back-pressure plus requested long hold-offs
    initial begin
        int stall_left;
        int stall_taken;
        stall_left = 0;
        stall_taken = 0;
        box_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_gen != stall_taken) begin
                stall_taken = stall_gen;
                stall_left = stall_len;
            end
            if (stall_left > 0) begin
                stall_left--;
                box_ch.ready <= 1'b0;
            end else begin
                box_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic int frame_dim(input int v);
        if (v == 0) return 1;
        if (v > ckbb_pkg::MAX_DIM) return ckbb_pkg::MAX_DIM;
        return v;
    endfunction

    function automatic ckbb_pkg::t_pixel pick_pixel(input int nonkey_pct);
        ckbb_pkg::t_pixel px;
        px = key_px;
        if ($urandom_range(99) < nonkey_pct) begin
            case ($urandom_range(3))
                0: px.blue = px.blue ^ (8'd1 << $urandom_range(7));
                1: px.green = px.green ^ (8'd1 << $urandom_range(7));
                2: px.red = px.red ^ (8'd1 << $urandom_range(7));
                default: px = ckbb_pkg::t_pixel'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(input ckbb_pkg::t_pixel px);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_blue <= px.blue;
        pix_ch.pixel_green <= px.green;
        pix_ch.pixel_red <= px.red;
        do @(posedge i_clk); while (!pix_ch.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ckbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ckbb_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_key(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        write_reg(ckbb_pkg::REG_KEY_RED, ckbb_pkg::CFG_W'(r));
        write_reg(ckbb_pkg::REG_KEY_GREEN, ckbb_pkg::CFG_W'(g));
        write_reg(ckbb_pkg::REG_KEY_BLUE, ckbb_pkg::CFG_W'(b));
        key_px.red = r;
        key_px.green = g;
        key_px.blue = b;
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(ckbb_pkg::REG_IMAGE_WIDTH, ckbb_pkg::CFG_W'(w));
        write_reg(ckbb_pkg::REG_IMAGE_HEIGHT, ckbb_pkg::CFG_W'(h));
        size_w = w;
        size_h = h;
    endtask

    task automatic write_unused();
        write_reg(ckbb_pkg::CFG_IDX_W'($urandom_range(int'(ckbb_pkg::REG_IMAGE_HEIGHT) + 1,
                                                       (1 << ckbb_pkg::CFG_IDX_W) - 1)),
                  ckbb_pkg::CFG_W'($urandom));
    endtask

    // pixels at raster index mark_a / mark_b are forced off the key color
    task automatic send_frame(input int nonkey_pct, input int mark_a, input int mark_b);
        int               n;
        ckbb_pkg::t_pixel px;
        n = frame_dim(size_w) * frame_dim(size_h);
        for (int i = 0; i < n; i++) begin
            px = pick_pixel(nonkey_pct);
            if (i == mark_a || i == mark_b) begin
                px = key_px;
                px.red = key_px.red ^ 8'h01;
            end
            push_pixel(px);
        end
    endtask

    task automatic random_group();
        int raw_w;
        int raw_h;
        int pct;
        int n;
        wait_drained();
        case ($urandom_range(3))
            0: set_key(8'h00, 8'h00, 8'h00);
            1: set_key(8'hFF, 8'hFF, 8'hFF);
            default: set_key(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
        case ($urandom_range(7))
            0: begin
                raw_w = 0;
                raw_h = $urandom_range(1, 6);
            end
            1: begin
                raw_w = $urandom_range(1, 6);
                raw_h = 0;
            end
            2: begin
                raw_w = $urandom_range(9, 40);
                raw_h = $urandom_range(1, 3);
            end
            3: begin
                raw_w = $urandom_range(1, 3);
                raw_h = $urandom_range(7, 16);
            end
            default: begin
                raw_w = $urandom_range(1, 8);
                raw_h = $urandom_range(1, 6);
            end
        endcase
        set_size(raw_w, raw_h);
        if ($urandom_range(5) == 0) begin
            write_unused();
        end
        n = frame_dim(size_w) * frame_dim(size_h);
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(4))
                0: pct = 0;
                1: pct = 3;
                2: pct = 15;
                3: pct = 50;
                default: pct = 100;
            endcase
            send_frame(pct, $urandom_range(1) ? $urandom_range(0, n - 1) : -1, -1);
        end
    endtask

    initial begin
        ckbb_pkg::t_pixel px;
        int               pass_start;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_blue = '0;
        pix_ch.pixel_green = '0;
        pix_ch.pixel_red = '0;
        send_idle_pct = 37;
        recv_idle_pct = 46;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key color, small frame with both corners marked
        set_size(8, 2);
        send_frame(3, 0, 15);

        // zero sizes act as 1x1: one found, one empty
        wait_drained();
        set_key(8'h5A, 8'hA5, 8'h3C);
        set_size(0, 0);
        send_frame(0, 0, -1);
        send_frame(0, -1, -1);

        wait_drained();
        set_size(5, 3);
        for (int i = 0; i < 15; i++) begin
            px = key_px;
            case (i)
                1: px = '0;
                2: px = '1;
                3: px.blue = ~key_px.blue;
                7: px.green = key_px.green ^ 8'h80;
                14: px.red = key_px.red ^ 8'h01;
                default: ;
            endcase
            push_pixel(px);
        end

        // writes to unmapped indexes must not disturb key or size
        wait_drained();
        set_size(3, 2);
        for (int k = int'(ckbb_pkg::REG_IMAGE_HEIGHT) + 1; k < (1 << ckbb_pkg::CFG_IDX_W);
             k++) begin
            write_reg(ckbb_pkg::CFG_IDX_W'(k), ckbb_pkg::CFG_W'($urandom));
        end
        send_frame(0, -1, -1);
        send_frame(30, 5, -1);

        for (int pass_idx = 0; pass_idx < 3; pass_idx++) begin
            case (pass_idx)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (pass_idx != 1) begin
                wait_drained();
                set_size(2, 2);
                @(posedge i_clk);
                stall_len = STALL_CYCLES;
                stall_gen++;
                repeat (10) send_frame(50, -1, -1);
            end
            pass_start = items_sent;
            while (items_sent - pass_start < ITEMS_PER_PASS) begin
                random_group();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
